[design/tst_pkg.sv]
// Shared types, codes and constants of the two-namespace symbol table.
`default_nettype none

package tst_pkg;

  localparam int WORD_W   = 64;
  localparam int BYTE_W   = 8;
  localparam int WORD_BYTES = WORD_W / BYTE_W;
  localparam int IDX_IN_W = 3;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  // Request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_REWIND = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Private namespace
  localparam logic NS_PRIVATE = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_WRITE_NAME,
    S_READ_VAL,
    S_RESULT
  } tst_state_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [IDX_IN_W-1:0] key_index;
    logic [WORD_W-1:0]   key_word;
    logic                name_space;
    logic [WORD_W-1:0]   entry_value;
  } tst_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   found_value;
    logic [SLOT_W-1:0]   slot;
  } tst_out_t;

endpackage

`default_nettype wire

[design/tst_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module tst_ram #(
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/tst_key_buf.sv]
// Key word buffer with null-terminated capture of the assembled key.
`default_nettype none

module tst_key_buf #(
  parameter int KEY_WORDS = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   load_en,
  input  wire logic [tst_pkg::IDX_IN_W-1:0]           load_idx,
  input  wire logic [tst_pkg::WORD_W-1:0]             load_word,
  output logic [KEY_WORDS-1:0][tst_pkg::WORD_W-1:0]   cap_key
);

  import tst_pkg::*;

  logic [KEY_WORDS-1:0][WORD_W-1:0] key_r;
  logic [KEY_WORDS-1:0]             word_has_zero;
  logic [KEY_WORDS:0]               zero_before;

  // Loads beyond the key length match no word and are dropped
  for (genvar w = 0; w < KEY_WORDS; w++) begin : g_word
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_r[w] <= '0;
      end else if (load_en && (load_idx == IDX_IN_W'(w))) begin
        key_r[w] <= load_word;
      end
    end
  end

  always_comb begin
    for (int w = 0; w < KEY_WORDS; w++) begin
      word_has_zero[w] = 1'b0;
      for (int b = 0; b < WORD_BYTES; b++) begin
        if (key_r[w][b*BYTE_W +: BYTE_W] == '0) begin
          word_has_zero[w] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    zero_before[0] = 1'b0;
    for (int w = 0; w < KEY_WORDS; w++) begin
      zero_before[w+1] = zero_before[w] | word_has_zero[w];
    end
  end

  // Keep each byte only while no zero byte has been seen so far
  always_comb begin
    logic seen;
    for (int w = 0; w < KEY_WORDS; w++) begin
      seen = zero_before[w];
      for (int b = 0; b < WORD_BYTES; b++) begin
        if (key_r[w][b*BYTE_W +: BYTE_W] == '0) begin
          seen = 1'b1;
        end
        cap_key[w][b*BYTE_W +: BYTE_W] = seen ? '0 : key_r[w][b*BYTE_W +: BYTE_W];
      end
    end
  end

endmodule

`default_nettype wire

[design/two_space_symbol_table.sv]
// Top level of the two-namespace symbol table: request sequencer and stores.
//
// Usage: requests arrive as beats on in_valid/in_stall/in_data; results leave
// as beats on out_valid/out_stall/out_data. A beat moves when valid is high
// and stall is low. Key-word loads and private-namespace rewinds give no
// result. Insert and lookup give exactly one result. Insert and lookup walk
// the chosen namespace word by word through the name RAM, one key word per
// cycle, entry by entry in order; a lookup hit then reads the value RAM, and
// a new name is written into the name RAM word by word. The single read port
// of the name RAM sets this rate. One item is worked on at a time:
// in_stall is high from acceptance of an insert or lookup until its result
// has moved into the output register. A finished result waits in that
// register while the next request is taken; when the receiver stalls, the
// result holds and a further result waits in its own state until the
// register frees.
// Reset (rst_n low, synchronous) empties both namespaces and zeroes the key
// buffer; the RAMs are not cleared, as only entries below the fill counts
// are ever read.
`default_nettype none

module two_space_symbol_table #(
  parameter int ENTRIES   = 64,
  parameter int KEY_WORDS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tst_pkg::tst_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output tst_pkg::tst_out_t     out_data
);

  import tst_pkg::*;

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int NAME_AW = 1 + EW + WW;
  localparam int VAL_AW  = 1 + EW;
  localparam logic [WW-1:0] LAST_W = WW'(KEY_WORDS - 1);

  tst_state_t state_r, state_nxt;

  // Per-item registers
  logic [1:0]        req_r;
  logic              ns_r;
  logic [WORD_W-1:0] val_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     count_r [2];

  // Read issue and compare stages of the search walk
  logic [EW-1:0] rd_e_r;
  logic [WW-1:0] rd_w_r;
  logic          issue_r;
  logic          cmp_v_r;
  logic [EW-1:0] cmp_e_r;
  logic [WW-1:0] cmp_w_r;
  logic          mism_r;
  logic          hit_r;
  logic [EW-1:0] hit_e_r;
  logic [WW-1:0] wr_w_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [WORD_W-1:0]   res_value_r;
  logic [SLOT_W-1:0]   res_slot_r;

  logic     out_valid_r;
  tst_out_t out_data_r;

  logic [KEY_WORDS-1:0][WORD_W-1:0] cap_key;

  logic               name_we;
  logic [NAME_AW-1:0] name_waddr, name_raddr;
  logic [WORD_W-1:0]  name_wdata, name_rdata;
  logic               val_we;
  logic [VAL_AW-1:0]  val_waddr, val_raddr;
  logic [WORD_W-1:0]  val_rdata;

  logic          accept, start, key_load, out_free;
  logic [CW-1:0] in_cnt, cnt_m1;
  logic [EW-1:0] last_e, new_e;
  logic          cmp_last, entry_eq, found_now, miss_now, search_end, full;
  logic [EW+SLOT_W-1:0] hit_slot_ext, new_slot_ext;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (in_data.req_type inside {REQ_INSERT, REQ_LOOKUP});
  assign key_load = accept && (in_data.req_type == REQ_LOAD);
  assign out_free = !out_valid_r || !out_stall;
  assign in_cnt   = count_r[in_data.name_space];

  assign cnt_m1 = cnt_r - 1'b1;
  assign last_e = cnt_m1[EW-1:0];
  assign new_e  = cnt_r[EW-1:0];
  assign full   = (cnt_r == CW'(ENTRIES));

  // An entry matches only if every word compared equal
  assign cmp_last   = (cmp_w_r == LAST_W);
  assign entry_eq   = (name_rdata == cap_key[cmp_w_r]) && ((cmp_w_r == '0) || !mism_r);
  assign found_now  = cmp_v_r && cmp_last && entry_eq;
  assign miss_now   = cmp_v_r && cmp_last && !entry_eq && (cmp_e_r == last_e);
  assign search_end = found_now || miss_now;

  // Slot reports the entry index modulo 64
  assign hit_slot_ext = {{SLOT_W{1'b0}}, hit_e_r};
  assign new_slot_ext = {{SLOT_W{1'b0}}, new_e};

  tst_key_buf #(
    .KEY_WORDS (KEY_WORDS)
  ) u_key_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (key_load),
    .load_idx  (in_data.key_index),
    .load_word (in_data.key_word),
    .cap_key   (cap_key)
  );

  tst_ram #(
    .WIDTH  (WORD_W),
    .ADDR_W (NAME_AW)
  ) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (name_wdata),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  tst_ram #(
    .WIDTH  (WORD_W),
    .ADDR_W (VAL_AW)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_r),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_cnt == '0) ? S_DECIDE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_end) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (req_r == REQ_INSERT) begin
          state_nxt = (hit_r || full) ? S_RESULT : S_WRITE_NAME;
        end else begin
          state_nxt = hit_r ? S_READ_VAL : S_RESULT;
        end
      end
      S_WRITE_NAME: begin
        if (wr_w_r == LAST_W) begin
          state_nxt = S_RESULT;
        end
      end
      S_READ_VAL: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory port controls
  always_comb begin
    name_we    = (state_r == S_WRITE_NAME);
    name_waddr = {ns_r, new_e, wr_w_r};
    name_wdata = cap_key[wr_w_r];
    name_raddr = {ns_r, rd_e_r, rd_w_r};
    val_we     = (state_r == S_DECIDE) && (req_r == REQ_INSERT) && (hit_r || !full);
    val_waddr  = {ns_r, hit_r ? hit_e_r : new_e};
    val_raddr  = {ns_r, hit_e_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state: fill counts, walk flags, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r[0]  <= '0;
      count_r[1]  <= '0;
      issue_r     <= 1'b0;
      cmp_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && (in_data.req_type == REQ_REWIND)) begin
        count_r[NS_PRIVATE] <= '0;
      end
      if (val_we && !hit_r) begin
        count_r[ns_r] <= cnt_r + 1'b1;
      end

      cmp_v_r <= (state_r == S_SEARCH) && issue_r && !search_end;

      if (start) begin
        issue_r <= 1'b1;
        hit_r   <= 1'b0;
      end else if (state_r == S_SEARCH) begin
        if (issue_r && (rd_w_r == LAST_W) && (rd_e_r == last_e)) begin
          issue_r <= 1'b0;
        end
        if (found_now) begin
          hit_r <= 1'b1;
        end
      end

      if ((state_r == S_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      req_r  <= in_data.req_type;
      ns_r   <= in_data.name_space;
      val_r  <= in_data.entry_value;
      cnt_r  <= in_cnt;
      rd_e_r <= '0;
      rd_w_r <= '0;
      wr_w_r <= '0;
      mism_r <= 1'b0;
    end

    // Advance the read address word by word, entry by entry
    if ((state_r == S_SEARCH) && issue_r) begin
      if (rd_w_r == LAST_W) begin
        rd_w_r <= '0;
        rd_e_r <= rd_e_r + 1'b1;
      end else begin
        rd_w_r <= rd_w_r + 1'b1;
      end
    end
    cmp_e_r <= rd_e_r;
    cmp_w_r <= rd_w_r;

    if (cmp_v_r) begin
      mism_r <= cmp_last ? 1'b0 : !entry_eq;
    end
    if ((state_r == S_SEARCH) && found_now) begin
      hit_e_r <= cmp_e_r;
    end

    if (state_r == S_WRITE_NAME) begin
      wr_w_r <= wr_w_r + 1'b1;
    end

    if (state_r == S_DECIDE) begin
      res_value_r <= '0;
      if (req_r == REQ_INSERT) begin
        if (hit_r) begin
          res_status_r <= ST_UPDATED;
          res_slot_r   <= hit_slot_ext[SLOT_W-1:0];
        end else if (full) begin
          res_status_r <= ST_FULL;
          res_slot_r   <= '0;
        end else begin
          res_status_r <= ST_INSERTED;
          res_slot_r   <= new_slot_ext[SLOT_W-1:0];
        end
      end else begin
        if (hit_r) begin
          res_status_r <= ST_FOUND;
          res_slot_r   <= hit_slot_ext[SLOT_W-1:0];
        end else begin
          res_status_r <= ST_NOT_FOUND;
          res_slot_r   <= '0;
        end
      end
    end

    if (state_r == S_READ_VAL) begin
      res_value_r <= val_rdata;
    end

    if ((state_r == S_RESULT) && out_free) begin
      out_data_r.status      <= res_status_r;
      out_data_r.found_value <= res_value_r;
      out_data_r.slot        <= res_slot_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Fill counts never pass capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[0] <= CW'(ENTRIES)) && (count_r[1] <= CW'(ENTRIES)))
    else $error("entry count beyond capacity");

  // A result beat is raised only from the result state
  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("output valid raised outside result state");

  // Value carried only on a successful lookup
  a_value_on_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_FOUND)) |-> (out_data_r.found_value == '0))
    else $error("found_value non-zero without a hit");

  // The value read follows a decision with a hit
  a_read_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ_VAL) |-> ($past(state_r == S_DECIDE) && hit_r))
    else $error("value read without a matching entry");

endmodule

`default_nettype wire

[test/tb_two_space_symbol_table.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the two-namespace symbol table, with its own shadow table.

module tb_two_space_symbol_table;
  import tst_pkg::*;

  localparam int ENTRIES      = 64;
  localparam int KEY_WORDS    = 8;
  localparam int NAME_BYTES   = KEY_WORDS * WORD_BYTES;
  localparam int POOL         = 16;      // names reused so that hits and updates happen
  localparam int RANDOM_BEATS = 300;
  localparam int LONG_HOLD    = 3000;    // receiver hold-off, well over two worst-case searches
  localparam int HOLD_AFTER   = 150;     // result beats seen before the hold-off starts
  localparam int SETTLE       = 600;     // a little over the longest item
  localparam int LIMIT        = 2_000_000;

  localparam logic NS_PUBLIC = 1'b1;

  typedef enum {STALL_NONE, STALL_SPARSE, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

  // One row of the directed part: the beat, and a typed-in result where it is obvious
  typedef struct packed {
    tst_in_t  item;
    logic     typed;
    tst_out_t want;
  } step_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tst_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tst_out_t out_data;

  // Typed-in result travelling alongside the beat on offer
  logic     lit_on;
  tst_out_t lit_want;

  // Shadow copy of the table
  logic [WORD_W-1:0] shadow_names  [2][ENTRIES][KEY_WORDS];
  logic [WORD_W-1:0] shadow_values [2][ENTRIES];
  int unsigned       shadow_count  [2];
  logic [WORD_W-1:0] shadow_key    [KEY_WORDS];

  tst_out_t pending_results[$];
  step_t    steps[$];

  logic [WORD_W-1:0] pool_words [POOL][KEY_WORDS];
  int                pool_len   [POOL];

  int errors       = 0;
  int results_seen = 0;
  int beats_sent   = 0;
  int burst_left   = 0;
  int cycles       = 0;

  two_space_symbol_table #(
    .ENTRIES  (ENTRIES),
    .KEY_WORDS(KEY_WORDS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, several times the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_two_space_symbol_table: FAIL");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic tst_in_t make_item(logic [1:0] req, logic [IDX_IN_W-1:0] idx,
                                        logic [WORD_W-1:0] word, logic ns,
                                        logic [WORD_W-1:0] val);
    tst_in_t it;
    it.req_type    = req;
    it.key_index   = idx;
    it.key_word    = word;
    it.name_space  = ns;
    it.entry_value = val;
    return it;
  endfunction

  // Apply one accepted beat to the shadow table; gives is set when a result follows
  function automatic tst_out_t resolve_request(input tst_in_t req, output bit gives);
    logic [WORD_W-1:0] captured [KEY_WORDS];
    logic [7:0]        ch;
    bit                seen;
    bit                same;
    int                hit;
    int unsigned       ns;
    tst_out_t          res;
    res   = '0;
    gives = 1'b0;
    seen  = 1'b0;
    hit   = -1;
    ns    = {31'b0, req.name_space};
    if (req.req_type == REQ_LOAD) begin
      if (req.key_index < KEY_WORDS) shadow_key[req.key_index] = req.key_word;
    end else if (req.req_type == REQ_REWIND) begin
      shadow_count[NS_PRIVATE] = 0;
    end else begin
      // Clear everything after the first zero character
      for (int w = 0; w < KEY_WORDS; w++) begin
        for (int b = 0; b < WORD_BYTES; b++) begin
          ch = shadow_key[w][BYTE_W*b +: BYTE_W];
          if (ch == 8'h00) seen = 1'b1;
          captured[w][BYTE_W*b +: BYTE_W] = seen ? 8'h00 : ch;
        end
      end
      // First match in entry order wins
      for (int i = 0; i < shadow_count[ns] && hit < 0; i++) begin
        same = 1'b1;
        for (int w = 0; w < KEY_WORDS; w++) begin
          if (shadow_names[ns][i][w] != captured[w]) same = 1'b0;
        end
        if (same) hit = i;
      end
      gives = 1'b1;
      if (req.req_type == REQ_INSERT) begin
        if (hit >= 0) begin
          shadow_values[ns][hit] = req.entry_value;
          res.status = ST_UPDATED;
          res.slot   = SLOT_W'(hit);
        end else if (shadow_count[ns] >= ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          for (int w = 0; w < KEY_WORDS; w++) shadow_names[ns][shadow_count[ns]][w] = captured[w];
          shadow_values[ns][shadow_count[ns]] = req.entry_value;
          res.status = ST_INSERTED;
          res.slot   = SLOT_W'(shadow_count[ns]);
          shadow_count[ns]++;
        end
      end else if (hit >= 0) begin
        res.status      = ST_FOUND;
        res.found_value = shadow_values[ns][hit];
        res.slot        = SLOT_W'(hit);
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    return res;
  endfunction

  // Check result beats against the oldest expectation, then predict the input beat.
  // Both are sampled at the rising edge, before the block's registers move.
  always @(posedge clk) begin : track
    tst_out_t want;
    tst_out_t predicted;
    bit       gives;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d slot %0d",
                 out_data.status, out_data.slot);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.found_value !== want.found_value) begin
            $error("found_value: expected %h, actual %h", want.found_value, out_data.found_value);
            errors++;
          end
          if (out_data.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, out_data.slot);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted = resolve_request(in_data, gives);
        if (gives) pending_results.push_back(lit_on ? lit_want : predicted);
      end
    end
  end

  // Receiver: stretches of different stall patterns, and one long hold-off that lets
  // the block back up and stall its input while the sender keeps offering beats
  initial begin : receiver
    stall_mode_t mode;
    int          span;
    bit          held;
    out_stall = 1'b0;
    held      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(10, 120);
        for (int k = 0; k < span; k++) begin
          @(negedge clk);
          case (mode)
            STALL_NONE:    out_stall <= 1'b0;
            STALL_SPARSE:  out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PATTERN: out_stall <= (k % 4 != 0);
            default:       out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Offer one beat and hold it until taken. The sender works in bursts with gaps
  // between them; a gap of zero keeps valid high straight through.
  task automatic send_beat(input tst_in_t item, input logic typed, input tst_out_t want);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    lit_on   <= typed;
    lit_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    beats_sent++;
  endtask

  task automatic offer(input tst_in_t item);
    send_beat(item, 1'b0, '0);
  endtask

  // Drop valid and hold off until every expected result has arrived
  task automatic drain_results();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Load key words 0..upto of a pooled name, in either order
  task automatic load_name(input int p, input int upto);
    bit desc;
    int w;
    desc = 1'($urandom_range(0, 1));
    for (int k = 0; k <= upto; k++) begin
      w = desc ? upto - k : k;
      offer(make_item(REQ_LOAD, IDX_IN_W'(w), pool_words[p][w], 1'($urandom), rand64()));
    end
  endtask

  // Insert one-character names until the namespace is full and beyond, then
  // revisit entries of the full table
  task automatic fill_namespace(input logic ns);
    for (int i = 0; i < ENTRIES + 2; i++) begin
      // garbage after the terminator must be ignored
      offer(make_item(REQ_LOAD, '0, {$urandom, 16'($urandom), 8'h00, 8'(i + 1)}, ns, rand64()));
      offer(make_item(REQ_INSERT, IDX_IN_W'($urandom), rand64(), ns, rand64()));
    end
    offer(make_item(REQ_LOAD, '0, 64'd11, ns, '0));
    offer(make_item(REQ_INSERT, '0, '0, ns, rand64()));
    offer(make_item(REQ_LOOKUP, '0, '0, ns, rand64()));
    offer(make_item(REQ_LOAD, '0, 64'd64, ns, '0));
    offer(make_item(REQ_LOOKUP, '0, '0, ns, '0));
    offer(make_item(REQ_LOAD, '0, 64'd66, ns, '0));
    offer(make_item(REQ_LOOKUP, '0, '0, ns, '0));
  endtask

  function automatic void add_step(input tst_in_t item, input logic typed,
                                   input logic [STATUS_W-1:0] st,
                                   input logic [WORD_W-1:0] fv, input logic [SLOT_W-1:0] sl);
    step_t s;
    s.item             = item;
    s.typed            = typed;
    s.want.status      = st;
    s.want.found_value = fv;
    s.want.slot        = sl;
    steps.push_back(s);
  endfunction

  initial begin : stimulus
    int p;
    int len;
    int last;
    int pick;
    int start;
    logic [1:0] req;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    lit_on   = 1'b0;
    lit_want = '0;
    shadow_count[0] = 0;
    shadow_count[1] = 0;
    for (int w = 0; w < KEY_WORDS; w++) shadow_key[w] = '0;

    // Build the name pool: every odd name shares a prefix with the one before it,
    // one character longer or shorter
    for (p = 0; p < POOL; p++) begin
      if (p % 2 == 0) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(16, NAME_BYTES) : $urandom_range(0, 15);
        for (int b = 0; b < NAME_BYTES; b++) begin
          pool_words[p][b / 8][8 * (b % 8) +: 8] =
            (b < len) ? 8'($urandom_range(1, 255)) : (b == len) ? 8'h00 : 8'($urandom);
        end
      end else begin
        for (int w = 0; w < KEY_WORDS; w++) pool_words[p][w] = pool_words[p - 1][w];
        len = pool_len[p - 1];
        if (len < NAME_BYTES) begin
          pool_words[p][len / 8][8 * (len % 8) +: 8] = 8'($urandom_range(1, 255));
          len++;
          if (len < NAME_BYTES) pool_words[p][len / 8][8 * (len % 8) +: 8] = 8'h00;
        end else begin
          len--;
          pool_words[p][len / 8][8 * (len % 8) +: 8] = 8'h00;
        end
      end
      pool_len[p] = len;
    end

    // Directed rows: empty tables, the empty name, extremes of value and key,
    // key capture at a terminator, a name with no terminator at all, rewind
    // of the private side with its stale entries, and the key kept across requests
    add_step(make_item(REQ_LOOKUP, '0, '0, NS_PRIVATE, '0), 1'b1, ST_NOT_FOUND, '0, '0);
    add_step(make_item(REQ_LOOKUP, '0, '0, NS_PUBLIC, '0), 1'b1, ST_NOT_FOUND, '0, '0);
    add_step(make_item(REQ_INSERT, '0, '0, NS_PRIVATE, '1), 1'b1, ST_INSERTED, '0, '0);
    add_step(make_item(REQ_LOOKUP, '0, '0, NS_PRIVATE, '0), 1'b1, ST_FOUND, '1, '0);
    add_step(make_item(REQ_LOAD, 3'd0, '1, NS_PRIVATE, '0), 1'b0, '0, '0, '0);
    add_step(make_item(REQ_INSERT, '0, '0, NS_PUBLIC, '0), 1'b1, ST_INSERTED, '0, '0);
    add_step(make_item(REQ_INSERT, '0, '0, NS_PUBLIC, 64'h8000_0000_0000_0001), 1'b1,
             ST_UPDATED, '0, '0);
    add_step(make_item(REQ_LOAD, 3'd7, '1, NS_PUBLIC, '1), 1'b0, '0, '0, '0);
    add_step(make_item(REQ_LOOKUP, '1, '1, NS_PUBLIC, '1), 1'b1, ST_FOUND,
             64'h8000_0000_0000_0001, '0);
    add_step(make_item(REQ_LOOKUP, '0, '0, NS_PRIVATE, '0), 1'b1, ST_NOT_FOUND, '0, '0);
    for (int i = 1; i < KEY_WORDS - 1; i++) begin
      add_step(make_item(REQ_LOAD, IDX_IN_W'(i), '1, NS_PRIVATE, '0), 1'b0, '0, '0, '0);
    end
    add_step(make_item(REQ_INSERT, '0, '0, NS_PUBLIC, 64'h0123_4567_89AB_CDEF), 1'b1,
             ST_INSERTED, '0, 6'd1);
    add_step(make_item(REQ_LOOKUP, '0, '0, NS_PUBLIC, '0), 1'b0, '0, '0, '0);
    add_step(make_item(REQ_LOAD, 3'd0, 64'h41, NS_PUBLIC, '0), 1'b0, '0, '0, '0);
    add_step(make_item(REQ_INSERT, '0, '0, NS_PRIVATE, 64'h5555_5555_5555_5555), 1'b1,
             ST_INSERTED, '0, 6'd1);
    add_step(make_item(REQ_REWIND, '1, '1, NS_PUBLIC, '1), 1'b0, '0, '0, '0);
    add_step(make_item(REQ_LOOKUP, '0, '0, NS_PRIVATE, '0), 1'b1, ST_NOT_FOUND, '0, '0);
    add_step(make_item(REQ_LOOKUP, '0, '0, NS_PUBLIC, '0), 1'b0, '0, '0, '0);
    add_step(make_item(REQ_INSERT, '0, '0, NS_PRIVATE, 64'hAAAA_AAAA_AAAA_AAAA), 1'b1,
             ST_INSERTED, '0, '0);
    add_step(make_item(REQ_LOOKUP, '0, '0, NS_PRIVATE, '0), 1'b0, '0, '0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < steps.size(); i++) send_beat(steps[i].item, steps[i].typed, steps[i].want);
    drain_results();

    // Private side to full and past it, then empty it again
    offer(make_item(REQ_REWIND, '0, '0, NS_PRIVATE, '0));
    fill_namespace(NS_PRIVATE);
    offer(make_item(REQ_REWIND, '0, '0, NS_PRIVATE, '0));
    drain_results();

    // Mostly well-formed sequences on pooled names, with noise, partly loaded keys
    // and the odd rewind mixed in
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      p    = $urandom_range(0, POOL - 1);
      last = (pool_len[p] >= NAME_BYTES) ? KEY_WORDS - 1 : pool_len[p] / 8;
      if (pick < 75) begin
        load_name(p, last);
        if (last < KEY_WORDS - 1 && $urandom_range(0, 3) == 0) begin
          offer(make_item(REQ_LOAD, IDX_IN_W'($urandom_range(last + 1, KEY_WORDS - 1)),
                          rand64(), 1'($urandom), rand64()));
        end
        repeat ($urandom_range(1, 2)) begin
          req = $urandom_range(0, 1) ? REQ_INSERT : REQ_LOOKUP;
          offer(make_item(req, IDX_IN_W'($urandom), rand64(), 1'($urandom), rand64()));
        end
      end else if (pick < 90) begin
        req = 2'($urandom_range(0, 3));
        if (req == REQ_REWIND && $urandom_range(0, 1) == 0) req = REQ_LOAD;
        offer(make_item(req, IDX_IN_W'($urandom), rand64(), 1'($urandom), rand64()));
      end else if (pick < 97) begin
        load_name(p, $urandom_range(0, last));
        req = $urandom_range(0, 1) ? REQ_INSERT : REQ_LOOKUP;
        offer(make_item(req, IDX_IN_W'($urandom), rand64(), 1'($urandom), rand64()));
      end else begin
        offer(make_item(REQ_REWIND, IDX_IN_W'($urandom), rand64(), 1'($urandom), rand64()));
      end
    end

    // Public side to full last, so the rest of the run is not starved of new entries
    fill_namespace(NS_PUBLIC);

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb_two_space_symbol_table: PASS");
    end else begin
      $display("tb_two_space_symbol_table: FAIL");
    end
    $finish;
  end

endmodule
